@@ rtl/gyro_angle_integrator_top_assert.svh @@
// Assertion macros for the gyro angle integrator.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef GYRO_ANGLE_INTEGRATOR_TOP_ASSERT_SVH
`define GYRO_ANGLE_INTEGRATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GAI_ASSERT_IMPL(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed: %m");

// next-cycle implication
`define GAI_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: %m");

`else

`define GAI_ASSERT_IMPL(label, clk, rst, cond, prop)
`define GAI_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

@@ rtl/gai_pkg.sv @@
// Shared widths, reset values and register indexes of the gyro angle integrator.
// No dependencies.
`default_nettype none

package gai_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int GAIN_FRAC_BITS = 24;
   localparam int GAIN_BITS      = 16;
   localparam int DEADBAND_BITS  = 15;
   localparam int LIMIT_BITS     = 7;
   localparam int ANGLE_BITS     = 8;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   // signed product of a sample and the unsigned gain
   localparam int PROD_BITS  = SAMPLE_BITS + GAIN_BITS + 1;
   localparam int SHIFT_BITS = ANGLE_BITS + GAIN_FRAC_BITS;
   localparam int SUM_BITS   = ((PROD_BITS > SHIFT_BITS) ? PROD_BITS : SHIFT_BITS) + 1;
   localparam int WHOLE_BITS = SUM_BITS - GAIN_FRAC_BITS;

   localparam logic [DEADBAND_BITS-1:0] DEADBAND_RESET  = DEADBAND_BITS'(245);
   localparam logic [GAIN_BITS-1:0]     RATE_GAIN_RESET = GAIN_BITS'(4178);
   localparam logic [LIMIT_BITS-1:0]    LIMIT_X_RESET   = LIMIT_BITS'(90);
   localparam logic [LIMIT_BITS-1:0]    LIMIT_YZ_RESET  = LIMIT_BITS'(45);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DEADBAND  = 2'd0,
      CSR_RATE_GAIN = 2'd1,
      CSR_LIMIT_X   = 2'd2,
      CSR_LIMIT_YZ  = 2'd3
   } csr_index_type;

endpackage

`default_nettype wire

@@ rtl/gai_if.sv @@
// Valid/ready channel interfaces for rate samples and angle results.
// Depends on gai_pkg.
`default_nettype none

interface gai_req_if;
   import gai_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_x;
   logic signed [SAMPLE_BITS-1:0] sample_y;
   logic signed [SAMPLE_BITS-1:0] sample_z;

   modport source (output valid, output sample_x, output sample_y, output sample_z,
                   input ready);
   modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                   output ready);
endinterface

interface gai_rsp_if;
   import gai_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [ANGLE_BITS-1:0] angle_x;
   logic signed [ANGLE_BITS-1:0] angle_y;
   logic signed [ANGLE_BITS-1:0] angle_z;

   modport source (output valid, output angle_x, output angle_y, output angle_z,
                   input ready);
   modport sink   (input valid, input angle_x, input angle_y, input angle_z,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/gyro_angle_integrator_top.sv @@
// Top level of the gyro angle integrator: stage register, three axis units,
// result register and configuration registers. Depends on gai_pkg, gai_if, gai_axis.
//
// Usage:
//   req_if carries one X/Y/Z rate sample triple per transaction; rsp_if returns
//   one X/Y/Z angle triple per transaction, in order. csr_we/csr_index/csr_wdata
//   write deadband, rate_gain, limit_x and limit_yz; write them only while idle.
//   Path: a sample triple taken from req_if goes into the stage register, then, once
//   the result slot is free, into the angle registers that drive rsp_if.
//   Throughput: one transaction per cycle while rsp_if does not stall, set by the
//   combinational path from the stage register through the axis multiply, add and
//   clamp into the angle registers, which also feed the next sample.
//   Reset (synchronous, active high) clears both stages and the angles and
//   loads the register defaults (245, 4178, 90, 45).
//   When rsp_if stalls, the result holds; one more transaction is taken into the
//   stage register, after which req_if.ready drops until the result drains.
`default_nettype none

`include "gyro_angle_integrator_top_assert.svh"

module gyro_angle_integrator_top (
   input  var logic                                clock,
   input  var logic                                reset,
   input  var logic                                csr_we,
   input  var gai_pkg::csr_index_type              csr_index,
   input  var logic [gai_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   gai_req_if.sink                                 req_if,
   gai_rsp_if.source                               rsp_if
);
   import gai_pkg::*;

   logic [DEADBAND_BITS-1:0] deadband_ff;
   logic [GAIN_BITS-1:0]     rate_gain_ff;
   logic [LIMIT_BITS-1:0]    limit_x_ff;
   logic [LIMIT_BITS-1:0]    limit_yz_ff;

   logic                          stage_valid_ff;
   logic                          stage_valid_in;
   logic signed [SAMPLE_BITS-1:0] sample_x_ff;
   logic signed [SAMPLE_BITS-1:0] sample_y_ff;
   logic signed [SAMPLE_BITS-1:0] sample_z_ff;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic signed [ANGLE_BITS-1:0] acc_x_ff;
   logic signed [ANGLE_BITS-1:0] acc_y_ff;
   logic signed [ANGLE_BITS-1:0] acc_z_ff;
   logic signed [ANGLE_BITS-1:0] acc_x_in;
   logic signed [ANGLE_BITS-1:0] acc_y_in;
   logic signed [ANGLE_BITS-1:0] acc_z_in;

   logic move;
   logic take;

   logic signed [ANGLE_BITS-1:0] lim_x_s;
   logic signed [ANGLE_BITS-1:0] lim_yz_s;
   logic [3*ANGLE_BITS-1:0]      angles_all;
   logic                         x_in_range;
   logic                         y_in_range;
   logic                         z_in_range;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff  <= DEADBAND_RESET;
         rate_gain_ff <= RATE_GAIN_RESET;
         limit_x_ff   <= LIMIT_X_RESET;
         limit_yz_ff  <= LIMIT_YZ_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEADBAND:  deadband_ff  <= csr_wdata[DEADBAND_BITS-1:0];
            CSR_RATE_GAIN: rate_gain_ff <= csr_wdata[GAIN_BITS-1:0];
            CSR_LIMIT_X:   limit_x_ff   <= csr_wdata[LIMIT_BITS-1:0];
            CSR_LIMIT_YZ:  limit_yz_ff  <= csr_wdata[LIMIT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // advance the stage into the result register when the result slot frees up
   assign move          = stage_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !stage_valid_ff || move;
   assign take          = req_if.valid && req_if.ready;

   always_comb begin
      stage_valid_in = take || (stage_valid_ff && !move);
      rsp_valid_in   = move || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         acc_x_ff       <= '0;
         acc_y_ff       <= '0;
         acc_z_ff       <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (move) begin
            acc_x_ff <= acc_x_in;
            acc_y_ff <= acc_y_in;
            acc_z_ff <= acc_z_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sample_x_ff <= req_if.sample_x;
         sample_y_ff <= req_if.sample_y;
         sample_z_ff <= req_if.sample_z;
      end
   end

   gai_axis u_axis_x (
      .acc      (acc_x_ff),
      .sample   (sample_x_ff),
      .deadband (deadband_ff),
      .gain     (rate_gain_ff),
      .limit    (limit_x_ff),
      .acc_next (acc_x_in)
   );

   gai_axis u_axis_y (
      .acc      (acc_y_ff),
      .sample   (sample_y_ff),
      .deadband (deadband_ff),
      .gain     (rate_gain_ff),
      .limit    (limit_yz_ff),
      .acc_next (acc_y_in)
   );

   gai_axis u_axis_z (
      .acc      (acc_z_ff),
      .sample   (sample_z_ff),
      .deadband (deadband_ff),
      .gain     (rate_gain_ff),
      .limit    (limit_yz_ff),
      .acc_next (acc_z_in)
   );

   // the kept angles double as the result payload
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.angle_x = acc_x_ff;
   assign rsp_if.angle_y = acc_y_ff;
   assign rsp_if.angle_z = acc_z_ff;

   assign lim_x_s    = $signed({1'b0, limit_x_ff});
   assign lim_yz_s   = $signed({1'b0, limit_yz_ff});
   assign angles_all = {acc_x_ff, acc_y_ff, acc_z_ff};
   assign x_in_range = (acc_x_ff <= lim_x_s) && (acc_x_ff >= -lim_x_s);
   assign y_in_range = (acc_y_ff <= lim_yz_s) && (acc_y_ff >= -lim_yz_s);
   assign z_in_range = (acc_z_ff <= lim_yz_s) && (acc_z_ff >= -lim_yz_s);

   `GAI_ASSERT_NEXT(a_take_fills_stage, clock, reset, take, stage_valid_ff)
   `GAI_ASSERT_NEXT(a_move_fills_rsp, clock, reset, move, rsp_valid_ff)
   `GAI_ASSERT_NEXT(a_angles_hold, clock, reset, !move, $stable(angles_all))
   `GAI_ASSERT_NEXT(a_x_within_limit, clock, reset, move, x_in_range)
   `GAI_ASSERT_NEXT(a_y_within_limit, clock, reset, move, y_in_range)
   `GAI_ASSERT_NEXT(a_z_within_limit, clock, reset, move, z_in_range)

endmodule

`default_nettype wire

@@ rtl/gai_axis.sv @@
// One axis of the integrator: deadband, gain multiply, accumulate, truncate, clamp.
// Depends on gai_pkg.
`default_nettype none

module gai_axis (
   input  var logic signed [gai_pkg::ANGLE_BITS-1:0]    acc,
   input  var logic signed [gai_pkg::SAMPLE_BITS-1:0]   sample,
   input  var logic        [gai_pkg::DEADBAND_BITS-1:0] deadband,
   input  var logic        [gai_pkg::GAIN_BITS-1:0]     gain,
   input  var logic        [gai_pkg::LIMIT_BITS-1:0]    limit,
   output logic signed     [gai_pkg::ANGLE_BITS-1:0]    acc_next
);
   import gai_pkg::*;

   logic        [SAMPLE_BITS-1:0] mag;
   logic signed [SAMPLE_BITS-1:0] live;
   logic signed [PROD_BITS-1:0]   prod;
   logic signed [SUM_BITS-1:0]    sum;
   logic signed [WHOLE_BITS-1:0]  whole;
   logic signed [WHOLE_BITS-1:0]  lim;
   logic signed [WHOLE_BITS-1:0]  clamped;

   always_comb begin
      // the most negative sample wraps to its true magnitude as unsigned
      mag  = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
      live = (32'(mag) < 32'(deadband)) ? '0 : sample;
      prod = PROD_BITS'(live) * $signed({1'b0, gain});
      sum  = (SUM_BITS'(acc) <<< GAIN_FRAC_BITS) + SUM_BITS'(prod);

      // floor, then bump negative values with a fraction to truncate toward zero
      whole = $signed(sum[SUM_BITS-1:GAIN_FRAC_BITS])
            + WHOLE_BITS'(sum[SUM_BITS-1] && (|sum[GAIN_FRAC_BITS-1:0]));

      lim = $signed(WHOLE_BITS'(limit));
      if (whole > lim) begin
         clamped = lim;
      end else if (whole < -lim) begin
         clamped = -lim;
      end else begin
         clamped = whole;
      end
      acc_next = ANGLE_BITS'(clamped);
   end

endmodule

`default_nettype wire
